// ===== rtl/lfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared constants for the frame classifier: frame limits, header type
// codes, verdict codes, message kinds and register indexes.
// ----------------------------------------------------------------------------
package lfc_pkg;

   localparam int MAX_FRAME_LEN  = 255;
   localparam int NUM_EUI_RANGES = 2;

   localparam int CNT_W   = $clog2(MAX_FRAME_LEN + 1);
   localparam int RCNT_W  = $clog2(NUM_EUI_RANGES + 1);
   localparam int CSR_IDX_W = $clog2(2 * NUM_EUI_RANGES + 3);
   localparam int CSR_DATA_W = 64;

   // frame layout
   localparam int JOIN_LEN     = 23;
   localparam int DATA_MIN_LEN = 12;
   localparam int FOPTS_START  = 8;
   localparam int MIC_LEN      = 4;

   // header fields
   localparam logic [4:0] HDR_RFU_MAJOR_MASK = 5'h1F;

   // frame type, header bits 7..5
   localparam logic [2:0] TYPE_JREQ   = 3'b000;
   localparam logic [2:0] TYPE_JACC   = 3'b001;
   localparam logic [2:0] TYPE_DAUP   = 3'b010;
   localparam logic [2:0] TYPE_DADN   = 3'b011;
   localparam logic [2:0] TYPE_DCUP   = 3'b100;
   localparam logic [2:0] TYPE_DCDN   = 3'b101;
   localparam logic [2:0] TYPE_REJOIN = 3'b110;
   localparam logic [2:0] TYPE_PROP   = 3'b111;

   // verdicts
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FILT = 2'd2;

   // message kinds
   localparam logic [2:0] KIND_PROP    = 3'd0;
   localparam logic [2:0] KIND_JACC    = 3'd1;
   localparam logic [2:0] KIND_JREQ    = 3'd2;
   localparam logic [2:0] KIND_REJOIN  = 3'd3;
   localparam logic [2:0] KIND_DATA_UP = 3'd4;
   localparam logic [2:0] KIND_DATA_DN = 3'd5;

   // register indexes; range i sits at CSR_EUI_BASE + 2*i (low) and +1 (high)
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_COUNT = CSR_IDX_W'(0);
   localparam int                   CSR_EUI_BASE    = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NETID_LOW   = CSR_IDX_W'(2 * NUM_EUI_RANGES + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_NETID_HIGH  = CSR_IDX_W'(2 * NUM_EUI_RANGES + 2);

   localparam logic [8:0] PORT_NONE = 9'h1FF;

endpackage
`default_nettype wire

// ===== rtl/lorawan_frame_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lorawan_frame_classifier
// Byte-wise frame parser: captures header fields by byte position and gives
// one verdict with the extracted fields at the last byte of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per transfer, req_last_byte marks the final byte.
//   rsp_*  : one result per frame, valid the cycle after the last byte is
//            taken, held in an output register until the receiver takes it.
//   csr_*  : register writes, taken at any edge with csr_write_en high;
//            write only while no frame is in progress.
// Throughput is one byte per cycle while req_stall is low. Each byte goes
// through position-decoded capture and the verdict logic in front of the
// output register.
// req_stall rises only while a result sits in the output register and the
// receiver stalls it; an unstalled receiver never slows the input.
// Reset (synchronous) clears the frame state, empties the output register,
// sets the range count to zero and the NetID accept mask to all ones.
// ----------------------------------------------------------------------------
module lorawan_frame_classifier (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [7:0]                    req_data_byte,
   input  wire                           req_last_byte,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [2:0]                    rsp_msg_kind,
   output logic [7:0]                    rsp_header,
   output logic [63:0]                   rsp_join_eui,
   output logic [63:0]                   rsp_dev_eui,
   output logic [15:0]                   rsp_dev_nonce,
   output logic [31:0]                   rsp_dev_addr,
   output logic [7:0]                    rsp_frame_ctrl,
   output logic [15:0]                   rsp_frame_count,
   output logic signed [8:0]             rsp_frame_port,
   output logic [7:0]                    rsp_payload_len,
   output logic [31:0]                   rsp_mic,
   input  wire                           csr_write_en,
   input  wire  [lfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [lfc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfc_pkg::*;

   // configuration
   logic [1:0]  range_count_ff;
   logic [63:0] eui_lo_ff [NUM_EUI_RANGES];
   logic [63:0] eui_hi_ff [NUM_EUI_RANGES];
   logic [63:0] netid_low_ff;
   logic [63:0] netid_high_ff;

   // frame state
   logic [CNT_W-1:0] count_ff, count_in;
   logic             too_long_ff, too_long_in;
   logic [7:0]       header_ff, header_in;
   logic [63:0]      join_eui_ff, join_eui_in;
   logic [63:0]      dev_eui_ff, dev_eui_in;
   logic [15:0]      nonce_ff, nonce_in;
   logic [31:0]      addr_ff, addr_in;
   logic [7:0]       ctrl_ff, ctrl_in;
   logic [15:0]      fcnt_ff, fcnt_in;
   logic [7:0]       port_ff, port_in;
   logic [31:0]      tail_ff, tail_in;

   // values after this byte is captured
   logic [CNT_W-1:0] cap_count;
   logic             cap_too_long;
   logic [7:0]       cap_header;
   logic [63:0]      cap_join_eui;
   logic [63:0]      cap_dev_eui;
   logic [15:0]      cap_nonce;
   logic [31:0]      cap_addr;
   logic [7:0]       cap_ctrl;
   logic [15:0]      cap_fcnt;
   logic [7:0]       cap_port;
   logic [31:0]      cap_tail;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [1:0]   status_ff, status_in;
   logic [2:0]   kind_ff, kind_in;
   logic [7:0]   hdr_out_ff, hdr_out_in;
   logic [63:0]  join_out_ff, join_out_in;
   logic [63:0]  dev_out_ff, dev_out_in;
   logic [15:0]  nonce_out_ff, nonce_out_in;
   logic [31:0]  addr_out_ff, addr_out_in;
   logic [7:0]   ctrl_out_ff, ctrl_out_in;
   logic [15:0]  fcnt_out_ff, fcnt_out_in;
   logic [8:0]   port_out_ff, port_out_in;
   logic [7:0]   plen_out_ff, plen_out_in;
   logic [31:0]  mic_out_ff, mic_out_in;

   logic             req_xfer;
   logic             frame_end;
   logic [2:0]       ftype;
   logic [CNT_W-1:0] port_pos;
   logic [CNT_W-1:0] port_pos_mic;
   logic [RCNT_W-1:0] ranges_active;
   logic             eui_pass;
   logic [6:0]       netid;
   logic [63:0]      netid_mask;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign frame_end = req_xfer & req_last_byte;

   // ---------------------------------------------------------------- capture
   always_comb begin
      cap_count    = count_ff;
      cap_too_long = too_long_ff;
      cap_header   = header_ff;
      cap_join_eui = join_eui_ff;
      cap_dev_eui  = dev_eui_ff;
      cap_nonce    = nonce_ff;
      cap_addr     = addr_ff;
      cap_ctrl     = ctrl_ff;
      cap_fcnt     = fcnt_ff;
      cap_port     = port_ff;
      cap_tail     = tail_ff;
      if (req_xfer && !too_long_ff) begin
         if (count_ff >= CNT_W'(MAX_FRAME_LEN)) begin
            cap_too_long = 1'b1;
         end else begin
            if (count_ff == CNT_W'(0)) begin
               cap_header = req_data_byte;
            end
            for (int k = 0; k < 8; k++) begin
               if (count_ff == CNT_W'(k + 1)) begin
                  cap_join_eui[8*k +: 8] = req_data_byte;
               end
               if (count_ff == CNT_W'(k + 9)) begin
                  cap_dev_eui[8*k +: 8] = req_data_byte;
               end
            end
            for (int k = 0; k < 2; k++) begin
               if (count_ff == CNT_W'(k + 17)) begin
                  cap_nonce[8*k +: 8] = req_data_byte;
               end
               if (count_ff == CNT_W'(k + 6)) begin
                  cap_fcnt[8*k +: 8] = req_data_byte;
               end
            end
            for (int k = 0; k < 4; k++) begin
               if (count_ff == CNT_W'(k + 1)) begin
                  cap_addr[8*k +: 8] = req_data_byte;
               end
            end
            if (count_ff == CNT_W'(5)) begin
               cap_ctrl = req_data_byte;
            end
            // port sits right after the FOpts, whose length the control byte gives
            if (count_ff == CNT_W'(FOPTS_START) + CNT_W'(ctrl_ff[3:0])) begin
               cap_port = req_data_byte;
            end
            cap_tail  = {req_data_byte, tail_ff[31:8]};
            cap_count = count_ff + CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- verdict
   assign ftype        = cap_header[7:5];
   assign port_pos     = CNT_W'(FOPTS_START) + CNT_W'(cap_ctrl[3:0]);
   assign port_pos_mic = port_pos + CNT_W'(MIC_LEN);
   assign netid        = cap_addr[31:25];
   assign netid_mask   = netid[6] ? netid_high_ff : netid_low_ff;

   always_comb begin
      if (range_count_ff > 2'(NUM_EUI_RANGES)) begin
         ranges_active = RCNT_W'(NUM_EUI_RANGES);
      end else begin
         ranges_active = RCNT_W'(range_count_ff);
      end
      eui_pass = (ranges_active == RCNT_W'(0));
      for (int i = 0; i < NUM_EUI_RANGES; i++) begin
         if (ranges_active > RCNT_W'(i) && cap_join_eui >= eui_lo_ff[i] &&
             cap_join_eui <= eui_hi_ff[i]) begin
            eui_pass = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (ftype)
         TYPE_JACC:              kind_in = KIND_JACC;
         TYPE_JREQ:              kind_in = KIND_JREQ;
         TYPE_REJOIN:            kind_in = KIND_REJOIN;
         TYPE_DAUP, TYPE_DCUP:   kind_in = KIND_DATA_UP;
         TYPE_DADN, TYPE_DCDN:   kind_in = KIND_DATA_DN;
         default:                kind_in = KIND_PROP;
      endcase
   end

   always_comb begin
      status_in    = ST_OK;
      hdr_out_in   = cap_header;
      mic_out_in   = cap_tail;
      join_out_in  = '0;
      dev_out_in   = '0;
      nonce_out_in = '0;
      addr_out_in  = '0;
      ctrl_out_in  = '0;
      fcnt_out_in  = '0;
      port_out_in  = '0;
      plen_out_in  = '0;
      priority if (cap_too_long || (cap_header[4:0] & HDR_RFU_MAJOR_MASK) != 5'd0 ||
                   (cap_count < CNT_W'(DATA_MIN_LEN) && ftype != TYPE_PROP)) begin
         status_in = ST_BAD;
      end else if (ftype == TYPE_PROP || ftype == TYPE_JACC) begin
         status_in = ST_OK;
      end else if (ftype == TYPE_JREQ || ftype == TYPE_REJOIN) begin
         if (cap_count != CNT_W'(JOIN_LEN)) begin
            status_in = ST_BAD;
         end else begin
            status_in    = eui_pass ? ST_OK : ST_FILT;
            join_out_in  = cap_join_eui;
            dev_out_in   = cap_dev_eui;
            nonce_out_in = cap_nonce;
         end
      end else begin
         if (port_pos_mic > cap_count) begin
            status_in = ST_BAD;
         end else begin
            status_in   = netid_mask[netid[5:0]] ? ST_OK : ST_FILT;
            addr_out_in = cap_addr;
            ctrl_out_in = cap_ctrl;
            fcnt_out_in = cap_fcnt;
            if (port_pos_mic == cap_count) begin
               port_out_in = PORT_NONE;
            end else begin
               port_out_in = {1'b0, cap_port};
               plen_out_in = 8'(cap_count - port_pos_mic - CNT_W'(1));
            end
         end
      end
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      if (frame_end) begin
         count_in    = '0;
         too_long_in = 1'b0;
         header_in   = '0;
         join_eui_in = '0;
         dev_eui_in  = '0;
         nonce_in    = '0;
         addr_in     = '0;
         ctrl_in     = '0;
         fcnt_in     = '0;
         port_in     = '0;
         tail_in     = '0;
      end else begin
         count_in    = cap_count;
         too_long_in = cap_too_long;
         header_in   = cap_header;
         join_eui_in = cap_join_eui;
         dev_eui_in  = cap_dev_eui;
         nonce_in    = cap_nonce;
         addr_in     = cap_addr;
         ctrl_in     = cap_ctrl;
         fcnt_in     = cap_fcnt;
         port_in     = cap_port;
         tail_in     = cap_tail;
      end
   end

   always_comb begin
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         too_long_ff  <= 1'b0;
         header_ff    <= '0;
         join_eui_ff  <= '0;
         dev_eui_ff   <= '0;
         nonce_ff     <= '0;
         addr_ff      <= '0;
         ctrl_ff      <= '0;
         fcnt_ff      <= '0;
         port_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         too_long_ff  <= too_long_in;
         header_ff    <= header_in;
         join_eui_ff  <= join_eui_in;
         dev_eui_ff   <= dev_eui_in;
         nonce_ff     <= nonce_in;
         addr_ff      <= addr_in;
         ctrl_ff      <= ctrl_in;
         fcnt_ff      <= fcnt_in;
         port_ff      <= port_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded only at the end of a frame
   always_ff @(posedge clock) begin
      if (frame_end) begin
         status_ff    <= status_in;
         kind_ff      <= kind_in;
         hdr_out_ff   <= hdr_out_in;
         join_out_ff  <= join_out_in;
         dev_out_ff   <= dev_out_in;
         nonce_out_ff <= nonce_out_in;
         addr_out_ff  <= addr_out_in;
         ctrl_out_ff  <= ctrl_out_in;
         fcnt_out_ff  <= fcnt_out_in;
         port_out_ff  <= port_out_in;
         plen_out_ff  <= plen_out_in;
         mic_out_ff   <= mic_out_in;
      end
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
         netid_low_ff   <= '1;
         netid_high_ff  <= '1;
         for (int i = 0; i < NUM_EUI_RANGES; i++) begin
            eui_lo_ff[i] <= '0;
            eui_hi_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_RANGE_COUNT) begin
            range_count_ff <= csr_wdata[1:0];
         end
         if (csr_index == CSR_NETID_LOW) begin
            netid_low_ff <= csr_wdata;
         end
         if (csr_index == CSR_NETID_HIGH) begin
            netid_high_ff <= csr_wdata;
         end
         for (int i = 0; i < NUM_EUI_RANGES; i++) begin
            if (csr_index == CSR_IDX_W'(CSR_EUI_BASE + 2 * i)) begin
               eui_lo_ff[i] <= csr_wdata;
            end
            if (csr_index == CSR_IDX_W'(CSR_EUI_BASE + 2 * i + 1)) begin
               eui_hi_ff[i] <= csr_wdata;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_msg_kind    = kind_ff;
   assign rsp_header      = hdr_out_ff;
   assign rsp_join_eui    = join_out_ff;
   assign rsp_dev_eui     = dev_out_ff;
   assign rsp_dev_nonce   = nonce_out_ff;
   assign rsp_dev_addr    = addr_out_ff;
   assign rsp_frame_ctrl  = ctrl_out_ff;
   assign rsp_frame_count = fcnt_out_ff;
   assign rsp_frame_port  = $signed(port_out_ff);
   assign rsp_payload_len = plen_out_ff;
   assign rsp_mic         = mic_out_ff;

endmodule
`default_nettype wire

// ===== bench/lorawan_frame_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorawan_frame_classifier_tb
// Self-checking bench for the frame classifier. Frames are built byte by
// byte and pushed through the request channel with random bursts and gaps.
// A byte-level predictor works out each verdict, and every result is
// compared field by field with the oldest pending verdict. The run covers
// directed frame kinds, malformed frames, EUI ranges, NetID masks, a long
// receiver hold-off and several random filter settings.
// ----------------------------------------------------------------------------
module lorawan_frame_classifier_tb;
   import lfc_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [2:0]  kind;
      logic [7:0]  header;
      logic [63:0] join_eui;
      logic [63:0] dev_eui;
      logic [15:0] dev_nonce;
      logic [31:0] dev_addr;
      logic [7:0]  frame_ctrl;
      logic [15:0] frame_count;
      logic [8:0]  frame_port;
      logic [7:0]  payload_len;
      logic [31:0] mic;
   } verdict_type;

   // index beyond the register map, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2 * NUM_EUI_RANGES + 3);
   localparam logic [63:0]          ALL_ONES  = '1;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_data_byte;
   logic                   req_last_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_status;
   logic [2:0]             rsp_msg_kind;
   logic [7:0]             rsp_header;
   logic [63:0]            rsp_join_eui;
   logic [63:0]            rsp_dev_eui;
   logic [15:0]            rsp_dev_nonce;
   logic [31:0]            rsp_dev_addr;
   logic [7:0]             rsp_frame_ctrl;
   logic [15:0]            rsp_frame_count;
   logic signed [8:0]      rsp_frame_port;
   logic [7:0]             rsp_payload_len;
   logic [31:0]            rsp_mic;
   logic                   csr_write_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // filter settings as the block should hold them
   logic [1:0]  cfg_range_count = '0;
   logic [63:0] cfg_eui_lo [NUM_EUI_RANGES] = '{default: '0};
   logic [63:0] cfg_eui_hi [NUM_EUI_RANGES] = '{default: '0};
   logic [63:0] cfg_netid_low  = '1;
   logic [63:0] cfg_netid_high = '1;

   // frame capture state of the predictor
   int          fr_len      = 0;
   bit          fr_too_long = 1'b0;
   logic [7:0]  fr_header   = '0;
   logic [63:0] fr_join_eui = '0;
   logic [63:0] fr_dev_eui  = '0;
   logic [15:0] fr_nonce    = '0;
   logic [31:0] fr_addr     = '0;
   logic [7:0]  fr_ctrl     = '0;
   logic [15:0] fr_fcnt     = '0;
   logic [7:0]  fr_port     = '0;
   logic [31:0] fr_tail     = '0;

   verdict_type verdicts_due[$];
   logic [7:0]  frame_buf[$];
   int          mismatches   = 0;
   int          bytes_sent   = 0;
   int          burst_left   = 0;
   int          hold_request = 0;

   lorawan_frame_classifier dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_msg_kind    (rsp_msg_kind),
      .rsp_header      (rsp_header),
      .rsp_join_eui    (rsp_join_eui),
      .rsp_dev_eui     (rsp_dev_eui),
      .rsp_dev_nonce   (rsp_dev_nonce),
      .rsp_dev_addr    (rsp_dev_addr),
      .rsp_frame_ctrl  (rsp_frame_ctrl),
      .rsp_frame_count (rsp_frame_count),
      .rsp_frame_port  (rsp_frame_port),
      .rsp_payload_len (rsp_payload_len),
      .rsp_mic         (rsp_mic),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor: absorbs one accepted byte, queues a verdict on the last one
   // ---------------------------------------------------------------------
   task automatic classify_byte(input logic [7:0] b, input bit last);
      verdict_type v;
      logic [2:0]  ftype;
      logic [6:0]  netid;
      logic [63:0] mask;
      int          n;
      int          portoff;
      bit          pass;
      if (!fr_too_long) begin
         if (fr_len >= MAX_FRAME_LEN) begin
            fr_too_long = 1'b1;
         end else begin
            // positions follow the join layout and the data layout at once
            if (fr_len == 0) fr_header = b;
            if (fr_len >= 1 && fr_len <= 8) fr_join_eui[8*(fr_len-1) +: 8] = b;
            if (fr_len >= 9 && fr_len <= 16) fr_dev_eui[8*(fr_len-9) +: 8] = b;
            if (fr_len == 17 || fr_len == 18) fr_nonce[8*(fr_len-17) +: 8] = b;
            if (fr_len >= 1 && fr_len <= 4) fr_addr[8*(fr_len-1) +: 8] = b;
            if (fr_len == 5) fr_ctrl = b;
            if (fr_len == 6 || fr_len == 7) fr_fcnt[8*(fr_len-6) +: 8] = b;
            if (fr_len >= FOPTS_START && fr_len == FOPTS_START + fr_ctrl[3:0]) fr_port = b;
            fr_tail = {b, fr_tail[31:8]};
            fr_len++;
         end
      end
      if (last) begin
         v = '{default: '0};
         ftype = fr_header[7:5];
         case (ftype)
            TYPE_JACC:              v.kind = KIND_JACC;
            TYPE_JREQ:              v.kind = KIND_JREQ;
            TYPE_REJOIN:            v.kind = KIND_REJOIN;
            TYPE_DAUP, TYPE_DCUP:   v.kind = KIND_DATA_UP;
            TYPE_DADN, TYPE_DCDN:   v.kind = KIND_DATA_DN;
            default:                v.kind = KIND_PROP;
         endcase
         v.header = fr_header;
         v.mic    = fr_tail;
         v.status = ST_OK;
         if (fr_too_long || (fr_header[4:0] & HDR_RFU_MAJOR_MASK) != '0 ||
             (fr_len < DATA_MIN_LEN && ftype != TYPE_PROP)) begin
            v.status = ST_BAD;
         end else if (ftype == TYPE_PROP || ftype == TYPE_JACC) begin
            v.status = ST_OK;
         end else if (ftype == TYPE_JREQ || ftype == TYPE_REJOIN) begin
            if (fr_len != JOIN_LEN) begin
               v.status = ST_BAD;
            end else begin
               n = (cfg_range_count > NUM_EUI_RANGES) ? NUM_EUI_RANGES : cfg_range_count;
               pass = (n == 0);
               for (int i = 0; i < n; i++)
                  if (fr_join_eui >= cfg_eui_lo[i] && fr_join_eui <= cfg_eui_hi[i]) pass = 1'b1;
               v.status    = pass ? ST_OK : ST_FILT;
               v.join_eui  = fr_join_eui;
               v.dev_eui   = fr_dev_eui;
               v.dev_nonce = fr_nonce;
            end
         end else begin
            portoff = FOPTS_START + fr_ctrl[3:0];
            if (portoff > fr_len - MIC_LEN) begin
               v.status = ST_BAD;
            end else begin
               netid = fr_addr[31:25];
               mask = netid[6] ? cfg_netid_high : cfg_netid_low;
               v.status      = mask[netid[5:0]] ? ST_OK : ST_FILT;
               v.dev_addr    = fr_addr;
               v.frame_ctrl  = fr_ctrl;
               v.frame_count = fr_fcnt;
               if (portoff == fr_len - MIC_LEN) begin
                  v.frame_port = PORT_NONE;
               end else begin
                  v.frame_port  = {1'b0, fr_port};
                  v.payload_len = 8'(fr_len - MIC_LEN - 1 - portoff);
               end
            end
         end
         verdicts_due.push_back(v);
         fr_len = 0; fr_too_long = 1'b0; fr_header = '0; fr_join_eui = '0;
         fr_dev_eui = '0; fr_nonce = '0; fr_addr = '0; fr_ctrl = '0;
         fr_fcnt = '0; fr_port = '0; fr_tail = '0;
      end
   endtask

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: result with no frame pending, expected none, actual status %h header %h",
                     $time, rsp_status, rsp_header);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            compare_field("status",      64'(want.status),      64'(rsp_status));
            compare_field("msg_kind",    64'(want.kind),        64'(rsp_msg_kind));
            compare_field("header",      64'(want.header),      64'(rsp_header));
            compare_field("join_eui",    want.join_eui,         rsp_join_eui);
            compare_field("dev_eui",     want.dev_eui,          rsp_dev_eui);
            compare_field("dev_nonce",   64'(want.dev_nonce),   64'(rsp_dev_nonce));
            compare_field("dev_addr",    64'(want.dev_addr),    64'(rsp_dev_addr));
            compare_field("frame_ctrl",  64'(want.frame_ctrl),  64'(rsp_frame_ctrl));
            compare_field("frame_count", 64'(want.frame_count), 64'(rsp_frame_count));
            compare_field("frame_port",  64'(want.frame_port),
                          64'($unsigned(rsp_frame_port)));
            compare_field("payload_len", 64'(want.payload_len), 64'(rsp_payload_len));
            compare_field("mic",         64'(want.mic),         64'(rsp_mic));
         end
      end
   end

   // receiver: random stall patterns, plus a long hold-off on request
   initial begin : receiver
      int hold_left;
      int stretch_left;
      int mode;
      hold_left = 0;
      stretch_left = 0;
      mode = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request <= 0;
         end
         if (stretch_left == 0) begin
            mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(10, 150);
         end
         stretch_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               2:       rsp_stall <= (stretch_left % 3 == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input bit last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer taken at this edge
      classify_byte(b, last);
      bytes_sent++;
   endtask

   task automatic make_frame(input logic [7:0] hdr, input int len);
      frame_buf.delete();
      frame_buf.push_back(hdr);
      for (int i = 1; i < len; i++) frame_buf.push_back(8'($urandom));
   endtask

   task automatic put_le(input int pos, input logic [63:0] val, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         if (pos + i < frame_buf.size()) frame_buf[pos+i] = val[8*i +: 8];
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic send_join(input logic [7:0] hdr, input logic [63:0] join_eui,
                            input logic [63:0] dev_eui, input int len);
      make_frame(hdr, len);
      put_le(1, join_eui, 8);
      put_le(9, dev_eui, 8);
      send_frame();
   endtask

   task automatic send_data(input logic [7:0] hdr, input logic [31:0] addr,
                            input logic [7:0] ctrl, input int len);
      make_frame(hdr, len);
      put_le(1, 64'(addr), 4);
      put_le(5, 64'(ctrl), 1);
      send_frame();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      // latency margin before anything is reconfigured
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      int k;
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_RANGE_COUNT) begin
         cfg_range_count = data[1:0];
      end else if (idx == CSR_NETID_LOW) begin
         cfg_netid_low = data;
      end else if (idx == CSR_NETID_HIGH) begin
         cfg_netid_high = data;
      end else if (idx >= CSR_EUI_BASE && idx < CSR_EUI_BASE + 2 * NUM_EUI_RANGES) begin
         k = idx - CSR_EUI_BASE;
         if (k % 2 == 0) cfg_eui_lo[k/2] = data;
         else cfg_eui_hi[k/2] = data;
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_filters(input logic [1:0] count, input logic [63:0] lo0,
                              input logic [63:0] hi0, input logic [63:0] lo1,
                              input logic [63:0] hi1, input logic [63:0] mask_low,
                              input logic [63:0] mask_high);
      wait_drained();
      csr_write(CSR_RANGE_COUNT, {62'd0, count});
      csr_write(CSR_IDX_W'(CSR_EUI_BASE),     lo0);
      csr_write(CSR_IDX_W'(CSR_EUI_BASE + 1), hi0);
      csr_write(CSR_IDX_W'(CSR_EUI_BASE + 2), lo1);
      csr_write(CSR_IDX_W'(CSR_EUI_BASE + 3), hi1);
      csr_write(CSR_NETID_LOW,  mask_low);
      csr_write(CSR_NETID_HIGH, mask_high);
   endtask

   function automatic logic [63:0] pick_eui();
      case ($urandom_range(0, 7))
         0:       return cfg_eui_lo[0];
         1:       return cfg_eui_hi[0];
         2:       return cfg_eui_lo[0] - 1;
         3:       return cfg_eui_hi[0] + 1;
         4:       return cfg_eui_lo[1];
         5:       return cfg_eui_hi[1];
         6:       return cfg_eui_hi[1] + 1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_random_frame();
      int         r;
      int         len;
      int         fopts;
      logic [2:0] ftype;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         ftype = $urandom_range(0, 1) ? TYPE_JREQ : TYPE_REJOIN;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : JOIN_LEN;
         send_join({ftype, 5'b0}, pick_eui(), {$urandom, $urandom}, len);
      end else if (r < 72) begin
         case ($urandom_range(0, 3))
            0:       ftype = TYPE_DAUP;
            1:       ftype = TYPE_DADN;
            2:       ftype = TYPE_DCUP;
            default: ftype = TYPE_DCDN;
         endcase
         fopts = $urandom_range(0, 15);
         r = $urandom_range(0, 39);
         if (r < 6) len = DATA_MIN_LEN + fopts;
         else if (r < 10) len = $urandom_range(DATA_MIN_LEN - 1, DATA_MIN_LEN + fopts - 1);
         else if (r == 10) len = $urandom_range(200, MAX_FRAME_LEN);
         else len = DATA_MIN_LEN + 1 + fopts + $urandom_range(0, 16);
         send_data({ftype, 5'b0}, $urandom, {4'($urandom), 4'(fopts)}, len);
      end else if (r < 82) begin
         make_frame({TYPE_PROP, 5'b0}, $urandom_range(1, 24));
         send_frame();
      end else if (r < 90) begin
         make_frame({TYPE_JACC, 5'b0}, $urandom_range(10, 33));
         send_frame();
      end else if (r < 99) begin
         // arbitrary header, usually with RFU or major bits set
         make_frame(8'($urandom), $urandom_range(1, 30));
         send_frame();
      end else begin
         make_frame(8'($urandom), $urandom_range(MAX_FRAME_LEN + 1, MAX_FRAME_LEN + 8));
         send_frame();
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_frame_kinds();
      // lone header byte: mic holds only that byte
      make_frame({TYPE_PROP, 5'b0}, 1);
      send_frame();
      make_frame({TYPE_PROP, 5'b0}, 3);
      send_frame();
      make_frame({TYPE_JACC, 5'b0}, 17);
      send_frame();
      send_join({TYPE_JREQ, 5'b0}, ALL_ONES, ALL_ONES, JOIN_LEN);
      send_join({TYPE_REJOIN, 5'b0}, '0, '0, JOIN_LEN);
      send_data({TYPE_DAUP, 5'b0}, 32'hFFFF_FFFF, 8'hFF, 40);
      // no room for a port byte
      send_data({TYPE_DADN, 5'b0}, 32'h0, 8'h00, DATA_MIN_LEN);
      // port present, empty payload
      send_data({TYPE_DCUP, 5'b0}, $urandom, 8'hA0, DATA_MIN_LEN + 1);
      send_data({TYPE_DCDN, 5'b0}, $urandom, 8'h00, MAX_FRAME_LEN);
   endtask

   task automatic test_malformed_frames();
      send_data({TYPE_DAUP, 5'b00001}, $urandom, 8'h00, 20);
      send_data({TYPE_DAUP, 5'b11100}, $urandom, 8'h00, 20);
      make_frame(8'hFF, 5);
      send_frame();
      send_data({TYPE_DAUP, 5'b0}, $urandom, 8'h00, DATA_MIN_LEN - 1);
      make_frame({TYPE_JACC, 5'b0}, DATA_MIN_LEN - 1);
      send_frame();
      send_join({TYPE_JREQ, 5'b0}, {$urandom, $urandom}, {$urandom, $urandom}, JOIN_LEN - 1);
      send_join({TYPE_REJOIN, 5'b0}, {$urandom, $urandom}, {$urandom, $urandom},
                JOIN_LEN + 1);
      // options run into the mic
      send_data({TYPE_DCUP, 5'b0}, $urandom, 8'h0F, FOPTS_START + 15 + MIC_LEN - 1);
      make_frame({TYPE_PROP, 5'b0}, MAX_FRAME_LEN + 1);
      send_frame();
   endtask

   task automatic test_eui_ranges();
      set_filters(2'd1, 64'h100, 64'h1FF, '0, '0, ALL_ONES, ALL_ONES);
      send_join({TYPE_JREQ, 5'b0}, 64'hFF, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_JREQ, 5'b0}, 64'h100, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_REJOIN, 5'b0}, 64'h1FF, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_REJOIN, 5'b0}, 64'h200, {$urandom, $urandom}, JOIN_LEN);
      // second range inverted, so it matches nothing
      set_filters(2'd2, '0, '0, 64'h400, 64'h300, ALL_ONES, ALL_ONES);
      send_join({TYPE_JREQ, 5'b0}, '0, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_JREQ, 5'b0}, 64'h350, {$urandom, $urandom}, JOIN_LEN);
      // count of three saturates to both ranges
      set_filters(2'd3, ALL_ONES, ALL_ONES, 64'h10, 64'h20, ALL_ONES, ALL_ONES);
      csr_write(CSR_SPARE, ALL_ONES);
      send_join({TYPE_JREQ, 5'b0}, ALL_ONES, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_REJOIN, 5'b0}, 64'h10, {$urandom, $urandom}, JOIN_LEN);
      send_join({TYPE_REJOIN, 5'b0}, 64'h21, {$urandom, $urandom}, JOIN_LEN);
   endtask

   task automatic test_netid_mask();
      logic [6:0] ids [5];
      ids = '{7'd0, 7'd1, 7'd63, 7'd64, 7'd127};
      for (int s = 0; s < 2; s++) begin
         if (s == 0) set_filters(2'd0, '0, '0, '0, '0, 64'h1, 64'h8000_0000_0000_0000);
         else set_filters(2'd0, '0, '0, '0, '0, 64'h8000_0000_0000_0000, 64'h1);
         foreach (ids[k]) send_data({TYPE_DCUP, 5'b0}, {ids[k], 25'($urandom)}, 8'h00, 14);
      end
   endtask

   task automatic test_input_backpressure();
      set_filters(2'd0, '0, '0, '0, '0, ALL_ONES, ALL_ONES);
      hold_request <= 400;
      burst_left = 500;
      repeat (30) begin
         make_frame({TYPE_PROP, 5'b0}, $urandom_range(1, 3));
         send_frame();
      end
   endtask

   task automatic test_random_traffic();
      logic [63:0] a;
      logic [63:0] b;
      int          start;
      for (int phase = 0; phase < 4; phase++) begin
         a = {$urandom, $urandom};
         b = {$urandom, $urandom};
         case (phase)
            0: set_filters(2'd0, a, b, b, a, ALL_ONES, ALL_ONES);
            1: set_filters(2'd1, (a < b) ? a : b, (a < b) ? b : a, '0, '0,
                           {$urandom, $urandom}, {$urandom, $urandom});
            2: set_filters(2'd2, a & b, a | b, a, b, {$urandom, $urandom} & {$urandom, $urandom},
                           {$urandom, $urandom} | {$urandom, $urandom});
            default: set_filters(2'd3, '0, a, b, ALL_ONES, '0, ALL_ONES);
         endcase
         start = bytes_sent;
         while (bytes_sent - start < 30) send_random_frame();
      end
   endtask

   initial begin : main
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_frame_kinds();
      test_malformed_frames();
      test_eui_ranges();
      test_netid_mask();
      test_input_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
